// ===== sv/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and constants of the character-cell text terminal engine.
// ----------------------------------------------------------------------------
package tte_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_INIT,     // clearing pass over the whole cell store after reset
        S_IDLE,     // waiting for an item
        S_CLEAR,    // erase-screen sweep over the area in use
        S_SCROLL,   // row copy, one cell per cycle
        S_BLANK,    // blank the last row after a scroll
        S_DONE      // result waits for the output register
    } t_state;

    // Escape sequence progress
    typedef enum logic [1:0] {
        ESC_IDLE,   // no sequence pending
        ESC_SEEN,   // ESC received
        ESC_CSI,    // ESC [ received
        ESC_PARAM   // ESC [ 2 received
    } t_esc;

    // Byte codes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_TWO      = 8'h32;
    localparam logic [7:0] CH_J        = 8'h4A;
    localparam logic [7:0] PRINT_LO    = 8'd32;
    localparam logic [7:0] PRINT_HI    = 8'd126;
    localparam logic [7:0] FINAL_LO    = 8'h40;
    localparam logic [7:0] FINAL_HI    = 8'h7E;
    localparam logic [6:0] BLANK       = 7'd32;

    // Opcodes
    localparam logic OP_READ = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET = 7'd25;

    // Effective geometry after range limiting
    typedef struct packed {
        logic [8:0] cols;
        logic [7:0] rows;
    } t_geom;

    // One result item
    typedef struct packed {
        logic [6:0]  cell_value;
        logic [7:0]  cursor_col;
        logic [6:0]  pos_row;
        logic [31:0] scrolls;
        logic        did_clear;
        logic        did_scroll;
        logic        did_write;
    } t_result;

endpackage

// ===== sv/tte_in_if.sv =====
// ----------------------------------------------------------------------------
// tte_in_if
// Input item channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface tte_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_in;
    logic [7:0] read_column;
    logic [6:0] read_row;

    modport source (output valid, opcode, char_in, read_column, read_row, input ready);
    modport sink   (input valid, opcode, char_in, read_column, read_row, output ready);
endinterface

// ===== sv/tte_out_if.sv =====
// ----------------------------------------------------------------------------
// tte_out_if
// Result item channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface tte_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  cell_value;
    logic [7:0]  cursor_col_out;
    logic [6:0]  cursor_row_out;
    logic [31:0] scrolls_total;
    logic        did_clear;
    logic        did_scroll;
    logic        did_write;

    modport source (output valid, cell_value, cursor_col_out, cursor_row_out,
                    scrolls_total, did_clear, did_scroll, did_write, input ready);
    modport sink   (input valid, cell_value, cursor_col_out, cursor_row_out,
                    scrolls_total, did_clear, did_scroll, did_write, output ready);
endinterface

// ===== sv/tte_cfg.sv =====
// ----------------------------------------------------------------------------
// tte_cfg
// APB register file for the screen geometry; gives the range-limited size.
// ----------------------------------------------------------------------------
module tte_cfg #(
    parameter int MAX_COLS  = 160,
    parameter int MAX_LINES = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tte_pkg::t_geom     o_geom
);
    import tte_pkg::*;

    localparam logic [8:0] MAX_C = 9'(MAX_COLS);
    localparam logic [7:0] MAX_R = 8'(MAX_LINES);

    logic [7:0] r_cols;
    logic [6:0] r_rows;

    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_COLS: r_cols <= pwdata[7:0];
                REG_ROWS: r_rows <= pwdata[6:0];
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            REG_COLS: prdata = {24'd0, r_cols};
            REG_ROWS: prdata = {25'd0, r_rows};
        endcase
    end

    // Zero acts as one, oversize acts as the store limit
    always_comb begin
        if (r_cols == 8'd0)
            o_geom.cols = 9'd1;
        else if ({1'b0, r_cols} > MAX_C)
            o_geom.cols = MAX_C;
        else
            o_geom.cols = {1'b0, r_cols};

        if (r_rows == 7'd0)
            o_geom.rows = 8'd1;
        else if ({1'b0, r_rows} > MAX_R)
            o_geom.rows = MAX_R;
        else
            o_geom.rows = {1'b0, r_rows};
    end

endmodule

// ===== sv/tte_engine.sv =====
// ----------------------------------------------------------------------------
// tte_engine
// Sequencer around the cell store: byte interpretation, cursor, escape
// tracking and the clear / scroll sweeps that read, move and write cells.
// ----------------------------------------------------------------------------
module tte_engine #(
    parameter int MAX_COLS  = 160,
    parameter int MAX_LINES = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tte_in_if.sink             i_in,
    input  tte_pkg::t_geom     i_geom,
    input  logic               i_res_free,
    output logic               o_res_valid,
    output tte_pkg::t_result   o_res
);
    import tte_pkg::*;

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int DEPTH = MAX_LINES * (2 ** CW);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [8:0] MAX_C = 9'(MAX_COLS);
    localparam logic [7:0] MAX_R = 8'(MAX_LINES);

    // Cell address: row in the upper bits, column in the lower bits
    function automatic logic [AW-1:0] cell_addr(input logic [6:0] row,
                                                input logic [7:0] col);
        logic [RW+CW-1:0] a;
        a = {row[RW-1:0], col[CW-1:0]};
        return AW'(a);
    endfunction

    // State
    t_state      r_state, n_state;
    t_esc        r_esc, n_esc;
    logic [7:0]  r_cur_col, n_col;
    logic [6:0]  r_cur_row, n_row;
    logic [31:0] r_scroll, n_scroll;
    logic [7:0]  r_sw_col, n_sw_col;
    logic [6:0]  r_sw_row, n_sw_row;
    logic        r_wb_valid, n_wb_valid;
    logic [AW-1:0] r_wb_addr, n_wb_addr;
    logic        r_is_read, n_is_read;
    logic        r_rd_ok, n_rd_ok;
    logic        r_f_clear, n_f_clear;
    logic        r_f_scroll, n_f_scroll;
    logic        r_f_write, n_f_write;

    // Cell store ports
    logic [6:0]    mem [DEPTH];
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [6:0]    mem_wdata;
    logic [6:0]    r_rdata;

    // Decode of the item at the input
    logic       in_acc;
    logic [7:0] ch;
    logic [7:0] col_s;
    logic [6:0] row_s;
    logic [8:0] col_inc;
    logic [7:0] row_inc;
    t_esc       d_esc;
    logic       d_clear, d_cr, d_lf, d_bs, d_print, d_nl, d_scroll, d_rd_ok;

    // Sweep limits
    logic [8:0] lim_c;
    logic [7:0] lim_r;
    logic       sw_last_col, sw_last_row;
    logic [7:0] sw_col_inc;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign ch         = i_in.char_in;

    // Cursor saturated to the area in use
    assign col_s   = ({1'b0, r_cur_col} >= i_geom.cols) ? 8'(i_geom.cols - 9'd1) : r_cur_col;
    assign row_s   = ({1'b0, r_cur_row} >= i_geom.rows) ? 7'(i_geom.rows - 8'd1) : r_cur_row;
    assign col_inc = {1'b0, col_s} + 9'd1;
    assign row_inc = {1'b0, row_s} + 8'd1;
    assign d_rd_ok = ({1'b0, i_in.read_column} < MAX_C) && ({1'b0, i_in.read_row} < MAX_R);

    // Byte interpretation
    always_comb begin
        d_esc   = r_esc;
        d_clear = 1'b0;
        d_cr    = 1'b0;
        d_lf    = 1'b0;
        d_bs    = 1'b0;
        d_print = 1'b0;
        if (r_esc != ESC_IDLE) begin
            if (r_esc == ESC_SEEN && ch == CH_LBRACKET) begin
                d_esc = ESC_CSI;
            end else if (r_esc == ESC_CSI && ch == CH_TWO) begin
                d_esc = ESC_PARAM;
            end else if (r_esc == ESC_PARAM && ch == CH_J) begin
                d_esc   = ESC_IDLE;
                d_clear = 1'b1;
            end else if (ch >= FINAL_LO && ch <= FINAL_HI) begin
                d_esc = ESC_IDLE;
            end
        end else if (ch == CH_ESC) begin
            d_esc = ESC_SEEN;
        end else if (ch == CH_CR) begin
            d_cr = 1'b1;
        end else if (ch == CH_LF) begin
            d_lf = 1'b1;
        end else if (ch == CH_BS) begin
            d_bs = 1'b1;
        end else if (ch >= PRINT_LO && ch <= PRINT_HI) begin
            d_print = 1'b1;
        end
        d_nl     = d_lf || (d_print && (col_inc >= i_geom.cols));
        d_scroll = d_nl && (row_inc >= i_geom.rows);
    end

    // Sweep position tests; the reset pass covers the whole store
    assign lim_c       = (r_state == S_INIT) ? MAX_C : i_geom.cols;
    assign lim_r       = (r_state == S_INIT) ? MAX_R : i_geom.rows;
    assign sw_last_col = ({1'b0, r_sw_col} == lim_c - 9'd1);
    assign sw_last_row = ({1'b0, r_sw_row} == lim_r - 8'd1);
    assign sw_col_inc  = r_sw_col + 8'd1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (sw_last_col && sw_last_row) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.opcode == OP_READ)
                        n_state = S_DONE;
                    else if (d_clear)
                        n_state = S_CLEAR;
                    else if (d_scroll)
                        n_state = (i_geom.rows > 8'd1) ? S_SCROLL : S_BLANK;
                    else
                        n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                if (sw_last_col && sw_last_row) n_state = S_DONE;
            end
            S_SCROLL: begin
                if (sw_last_col && sw_last_row) n_state = S_BLANK;
            end
            S_BLANK: begin
                if (!r_wb_valid && sw_last_col) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // Datapath, store accesses and result
    always_comb begin
        n_esc       = r_esc;
        n_col       = r_cur_col;
        n_row       = r_cur_row;
        n_scroll    = r_scroll;
        n_sw_col    = r_sw_col;
        n_sw_row    = r_sw_row;
        n_wb_valid  = 1'b0;
        n_wb_addr   = r_wb_addr;
        n_is_read   = r_is_read;
        n_rd_ok     = r_rd_ok;
        n_f_clear   = r_f_clear;
        n_f_scroll  = r_f_scroll;
        n_f_write   = r_f_write;
        mem_we      = 1'b0;
        mem_waddr   = cell_addr(r_sw_row, r_sw_col);
        mem_wdata   = BLANK;
        mem_re      = 1'b0;
        mem_raddr   = cell_addr(i_in.read_row, i_in.read_column);
        o_res_valid = 1'b0;

        unique case (r_state)
            // blank sweep, row by row
            S_INIT, S_CLEAR: begin
                mem_we = 1'b1;
                if (sw_last_col) begin
                    n_sw_col = 8'd0;
                    n_sw_row = r_sw_row + 7'd1;
                end else begin
                    n_sw_col = sw_col_inc;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_is_read  = (i_in.opcode == OP_READ);
                    n_f_clear  = 1'b0;
                    n_f_scroll = 1'b0;
                    n_f_write  = 1'b0;
                    if (i_in.opcode == OP_READ) begin
                        mem_re  = d_rd_ok;
                        n_rd_ok = d_rd_ok;
                    end else begin
                        n_esc      = d_esc;
                        n_col      = col_s;
                        n_row      = row_s;
                        n_f_clear  = d_clear;
                        n_f_scroll = d_scroll;
                        n_f_write  = d_print;
                        n_sw_col   = 8'd0;
                        if (d_clear) begin
                            n_col    = 8'd0;
                            n_row    = 7'd0;
                            n_sw_row = 7'd0;
                        end else if (d_cr) begin
                            n_col = 8'd0;
                        end else if (d_bs && col_s != 8'd0) begin
                            n_col     = col_s - 8'd1;
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(row_s, col_s - 8'd1);
                            mem_wdata = BLANK;
                        end else if (d_print) begin
                            n_col     = col_inc[7:0];
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(row_s, col_s);
                            mem_wdata = ch[6:0];
                        end
                        // new line, possibly with scroll
                        if (d_nl) begin
                            n_col = 8'd0;
                            n_row = d_scroll ? 7'(i_geom.rows - 8'd1) : row_inc[6:0];
                        end
                        if (d_scroll) begin
                            n_scroll = r_scroll + 32'd1;
                            n_sw_row = {6'd0, (i_geom.rows > 8'd1)};
                        end
                    end
                end
            end
            // read row r, write the cell to row r-1 in the next cycle
            S_SCROLL: begin
                mem_re     = 1'b1;
                mem_raddr  = cell_addr(r_sw_row, r_sw_col);
                n_wb_valid = 1'b1;
                n_wb_addr  = cell_addr(r_sw_row - 7'd1, r_sw_col);
                if (r_wb_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wb_addr;
                    mem_wdata = r_rdata;
                end
                if (sw_last_col) begin
                    n_sw_col = 8'd0;
                    if (!sw_last_row) n_sw_row = r_sw_row + 7'd1;
                end else begin
                    n_sw_col = sw_col_inc;
                end
            end
            // last copy drains first, then the bottom row is blanked
            S_BLANK: begin
                mem_we = 1'b1;
                if (r_wb_valid) begin
                    mem_waddr = r_wb_addr;
                    mem_wdata = r_rdata;
                end else begin
                    n_sw_col = sw_col_inc;
                end
            end
            S_DONE: begin
                o_res_valid = i_res_free;
            end
            default: ;
        endcase

        o_res.cell_value = (r_is_read && r_rd_ok) ? r_rdata : 7'd0;
        o_res.cursor_col = r_cur_col;
        o_res.pos_row    = r_cur_row;
        o_res.scrolls    = r_scroll;
        o_res.did_clear  = r_f_clear;
        o_res.did_scroll = r_f_scroll;
        o_res.did_write  = r_f_write;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_esc      <= ESC_IDLE;
            r_cur_col  <= 8'd0;
            r_cur_row  <= 7'd0;
            r_scroll   <= 32'd0;
            r_sw_col   <= 8'd0;
            r_sw_row   <= 7'd0;
            r_wb_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_esc      <= n_esc;
            r_cur_col  <= n_col;
            r_cur_row  <= n_row;
            r_scroll   <= n_scroll;
            r_sw_col   <= n_sw_col;
            r_sw_row   <= n_sw_row;
            r_wb_valid <= n_wb_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_wb_addr  <= n_wb_addr;
        r_is_read  <= n_is_read;
        r_rd_ok    <= n_rd_ok;
        r_f_clear  <= n_f_clear;
        r_f_scroll <= n_f_scroll;
        r_f_write  <= n_f_write;
    end

    // Cell store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    // Scroll count only ever steps by one
    a_scroll_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_scroll != $past(r_scroll)) |-> r_scroll == $past(r_scroll) + 32'd1)
        else $error("scroll counter jumped");

    // Row copy never reads the cell it writes in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("read and write hit the same cell");

    // While idle the store is written only by an accepted put
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && (r_state == S_IDLE) |-> in_acc && (i_in.opcode != OP_READ))
        else $error("stray cell write while idle");

    // A pending copy exists only inside the scroll sweep
    a_wb_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> (r_state == S_SCROLL) || (r_state == S_BLANK))
        else $error("write-back pending outside scroll");

endmodule

// ===== sv/text_terminal_cell_engine.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cell_engine
// Character-cell text terminal: cell store, cursor, escape handling, scroll.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per handshake: a put (opcode 0) interprets char_in,
//   a read (opcode 1) returns the cell at read_column/read_row. Every item
//   gives exactly one item on o_out, with the cursor and scroll count after it.
//   The APB port sets columns and rows in use; write it only while idle.
// Sequencing:
//   A read or an ordinary byte goes from accept to the done state, then to
//   the output register; the next item is accepted in the cycle after the
//   result is loaded. ESC [ 2 J adds a clear sweep, one cell blanked per cycle.
//   A scroll adds a row copy sweep (not with one row in use) and a blank sweep:
//   each cell is read and written back one row up through the single write
//   port, then the bottom row is blanked.
// Reset:
//   After reset the whole store (MAX_COLS*MAX_LINES cells, 16000 by default)
//   is set to spaces, one cell per cycle, with i_in.ready low.
// Back-pressure:
//   The result sits in an output register; while that register is full and
//   o_out.ready is low the sequencer holds its finished result and accepts no new item.
// ----------------------------------------------------------------------------
module text_terminal_cell_engine #(
    parameter int MAX_COLS  = 160,
    parameter int MAX_LINES = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tte_in_if.sink      i_in,
    tte_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tte_pkg::*;

    t_geom   geom;
    t_result res;
    logic    res_valid;
    logic    res_free;
    logic    r_out_valid;
    t_result r_out;

    tte_cfg #(
        .MAX_COLS  (MAX_COLS),
        .MAX_LINES (MAX_LINES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom)
    );

    tte_engine #(
        .MAX_COLS  (MAX_COLS),
        .MAX_LINES (MAX_LINES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_geom      (geom),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register
    assign res_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) r_out <= res;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.cell_value     = r_out.cell_value;
    assign o_out.cursor_col_out = r_out.cursor_col;
    assign o_out.cursor_row_out = r_out.pos_row;
    assign o_out.scrolls_total  = r_out.scrolls;
    assign o_out.did_clear      = r_out.did_clear;
    assign o_out.did_scroll     = r_out.did_scroll;
    assign o_out.did_write      = r_out.did_write;

endmodule
